// File: src/fbbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbbc_pkg;

	localparam int HEADER_LEN    = 16;
	localparam int MAX_BLOCK_LEN = 65536;

	localparam logic [7:0] FLASH_ERASED = 8'hff;

	// header magic, offsets 0..7
	localparam logic [7:0] MAGIC [8] = '{
		8'h5a, 8'h53, 8'h42, 8'h4f, 8'h4f, 8'h54, 8'h30, 8'h31
	};

	typedef enum logic [1:0] {
		CMD_OPEN  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_INCR  = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_NONE    = 2'd0,
		OP_ERASE   = 2'd1,
		OP_HEADER  = 2'd2,
		OP_PROGRAM = 2'd3
	} op_t;

	localparam logic CFG_FLASH_BASE = 1'b0;
	localparam logic CFG_BLOCK_SIZE = 1'b1;

	// everything one command produces, before it is split into beats
	typedef struct packed {
		logic        reformat;   // erase + header beats come first
		logic        prog;       // final beat programs a bitmap byte
		logic [31:0] base_addr;
		logic [31:0] byte_addr;
		logic [7:0]  pbyte;
		logic [31:0] new_base;
		logic [31:0] value;
		logic        formatted;
	} res_t;

	function automatic logic [3:0] count_zeros(input logic [7:0] b);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(!b[i]);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: src/fbbc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module fbbc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire fbbc_pkg::cmd_t    cmd,
	input  wire logic [15:0]       byte_offset,
	input  wire logic [7:0]        data_byte,
	input  wire logic [31:0]       flash_base,
	input  wire logic [16:0]       block_size,
	output fbbc_pkg::res_t         res
);
	import fbbc_pkg::*;

	logic [31:0] base_q, base_n;
	logic [19:0] used_q, used_n;
	logic        fmt_q, fmt_n;
	logic        magic_q, magic_n;
	logic [31:0] check_q, check_n;
	logic        stop_q, stop_n;

	logic [16:0] size_eff;
	logic        usable;
	logic [19:0] cap;
	logic [20:0] used_sum;
	logic [31:0] base_p;
	logic [19:0] used_p;
	logic [15:0] pb_wide;
	logic        reformat;

	always_comb begin
		size_eff = (block_size > 17'(MAX_BLOCK_LEN)) ? 17'(MAX_BLOCK_LEN) : block_size;
		usable   = size_eff > 17'(HEADER_LEN);
		cap      = {size_eff - 17'(HEADER_LEN), 3'b000};
		used_sum = {1'b0, used_q} + 21'(count_zeros(data_byte));
		reformat = !fmt_q || (used_q >= cap);
		base_p   = fmt_q ? base_q + 32'(used_q) : '0;
		used_p   = reformat ? '0 : used_q;
		pb_wide  = 16'h00ff << ({1'b0, used_p[2:0]} + 4'd1);
	end

	// next state
	always_comb begin
		base_n  = base_q;
		used_n  = used_q;
		fmt_n   = fmt_q;
		magic_n = magic_q;
		check_n = check_q;
		stop_n  = stop_q;
		unique case (cmd)
			CMD_OPEN: begin
				base_n  = '0;
				used_n  = '0;
				fmt_n   = 1'b0;
				magic_n = 1'b0;
				check_n = '0;
				stop_n  = 1'b0;
			end
			CMD_READ: begin
				if (usable && ({1'b0, byte_offset} < size_eff)) begin
					if (byte_offset[15:4] == '0) begin
						if (!fmt_q) begin
							if (!byte_offset[3]) begin
								magic_n = (data_byte == MAGIC[byte_offset[2:0]]) &&
									(byte_offset[2:0] == 3'd0 || magic_q);
							end else if (!byte_offset[2]) begin
								base_n[8*byte_offset[1:0] +: 8] = data_byte;
							end else begin
								check_n[8*byte_offset[1:0] +: 8] = data_byte;
							end
							// last header byte decides the format
							if (byte_offset[3:0] == 4'(HEADER_LEN - 1)) begin
								fmt_n  = magic_q && (base_q == ~check_n);
								used_n = '0;
								stop_n = 1'b0;
							end
						end
					end else if (fmt_q && !stop_q) begin
						if (data_byte == FLASH_ERASED) begin
							stop_n = 1'b1;
						end else begin
							used_n = (used_sum > {1'b0, cap}) ? cap : used_sum[19:0];
							if (data_byte != '0) stop_n = 1'b1;
						end
					end
				end
			end
			CMD_INCR: begin
				if (usable) begin
					stop_n = 1'b1;
					if (reformat) begin
						base_n  = base_p;
						check_n = ~base_p;
						magic_n = 1'b1;
						fmt_n   = 1'b1;
					end
					used_n = used_p + 20'd1;
				end
			end
			default: ;
		endcase
	end

	// result set: value and formatted from the state after the command, flash beat fields from the state before it
	always_comb begin
		res.reformat  = (cmd == CMD_INCR) && usable && reformat;
		res.prog      = (cmd == CMD_INCR) && usable;
		res.base_addr = flash_base;
		res.byte_addr = flash_base + 32'(HEADER_LEN) + 32'(used_p[19:3]);
		res.pbyte     = pb_wide[7:0];
		res.new_base  = base_p;
		res.value     = fmt_n ? base_n + 32'(used_n) : '0;
		res.formatted = fmt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			used_q  <= '0;
			fmt_q   <= 1'b0;
			magic_q <= 1'b0;
			check_q <= '0;
			stop_q  <= 1'b0;
		end else if (step) begin
			base_q  <= base_n;
			used_q  <= used_n;
			fmt_q   <= fmt_n;
			magic_q <= magic_n;
			check_q <= check_n;
			stop_q  <= stop_n;
		end
	end

endmodule

`default_nettype wire

// File: src/fbbc_out.sv
`timescale 1ns / 1ps
`default_nettype none

module fbbc_out (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire fbbc_pkg::res_t res,
	output logic                free,
	output logic                tvalid,
	input  wire logic           tready,
	output fbbc_pkg::op_t       op,
	output logic [31:0]         address,
	output logic [7:0]          pbyte,
	output logic [31:0]         hbase,
	output logic [31:0]         value,
	output logic                formatted,
	output logic                last
);
	import fbbc_pkg::*;

	res_t       res_s2;
	logic       valid_s2;
	logic [1:0] beat_q;

	always_comb begin
		last      = !res_s2.reformat || (beat_q == 2'd2);
		free      = !valid_s2 || (tready && last);
		tvalid    = valid_s2;
		value     = res_s2.value;
		formatted = res_s2.formatted;
		op        = OP_NONE;
		address   = '0;
		pbyte     = '0;
		hbase     = '0;
		if (res_s2.reformat && beat_q == 2'd0) begin
			op      = OP_ERASE;
			address = res_s2.base_addr;
		end else if (res_s2.reformat && beat_q == 2'd1) begin
			op      = OP_HEADER;
			address = res_s2.base_addr;
			hbase   = res_s2.new_base;
		end else if (res_s2.prog) begin
			op      = OP_PROGRAM;
			address = res_s2.byte_addr;
			pbyte   = res_s2.pbyte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			beat_q   <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			beat_q   <= '0;
		end else if (valid_s2 && tready) begin
			if (last) valid_s2 <= 1'b0;
			beat_q <= beat_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_s2 <= res;
	end

endmodule

`default_nettype wire

// File: src/flash_bitmap_boot_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: cmd; tdata: byte_offset, data_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser: flash_op; tdata: address, byte,
//                                             header base, value, formatted; tlast
// cfg       in   cfg_wr_en (no wait)          cfg_index, cfg_data
//
// One item per cycle in while the output does not stall: s1 input register, then the
// step logic writes the counter state and the whole result set into the s2 result register.
// An increment that reformats yields three beats (erase, header, program),
// every other command one; the output beat count sets the sustained rate.
// s1 refills while s2 drains its last beat, so no bubble between items.
// arst_n clears state and valid flags and resets config (block size to 4096); nothing needs a clearing pass.

module flash_bitmap_boot_counter (
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [23:0]  s_axis_tdata,   // [15:0] byte_offset, [23:16] data_byte
	input  wire logic [1:0]   s_axis_tuser,   // [1:0] cmd

	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [111:0]      m_axis_tdata,   // [31:0] flash_address, [39:32] program_byte,
	                                          // [71:40] header_base, [103:72] counter_value,
	                                          // [104] is_formatted, rest zero
	output logic [1:0]        m_axis_tuser,   // [1:0] flash_op
	output logic              m_axis_tlast,

	input  wire logic         cfg_wr_en,
	input  wire logic         cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import fbbc_pkg::*;

	logic [31:0] flash_base_q;
	logic [16:0] block_size_q;

	// input register
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [15:0] offset_s1;
	logic [7:0]  data_s1;

	logic  free;
	logic  load;
	res_t  res;
	op_t   op;
	logic [31:0] address, hbase, value;
	logic [7:0]  pbyte;
	logic        formatted;

	assign load          = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_base_q <= '0;
			block_size_q <= 17'd4096;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FLASH_BASE: flash_base_q <= cfg_data;
				CFG_BLOCK_SIZE: block_size_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1    <= cmd_t'(s_axis_tuser);
			offset_s1 <= s_axis_tdata[15:0];
			data_s1   <= s_axis_tdata[23:16];
		end
	end

	fbbc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (load),
		.cmd         (cmd_s1),
		.byte_offset (offset_s1),
		.data_byte   (data_s1),
		.flash_base  (flash_base_q),
		.block_size  (block_size_q),
		.res         (res)
	);

	fbbc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.free      (free),
		.tvalid    (m_axis_tvalid),
		.tready    (m_axis_tready),
		.op        (op),
		.address   (address),
		.pbyte     (pbyte),
		.hbase     (hbase),
		.value     (value),
		.formatted (formatted),
		.last      (m_axis_tlast)
	);

	assign m_axis_tuser = op;
	assign m_axis_tdata = {7'd0, formatted, value, hbase, pbyte, address};

	// a held item in s1 blocks the input unless it moves on this cycle
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load) |-> !s_axis_tready)
		else $error("input taken while s1 full");

	// erase is always followed by the header program
	a_erase_then_header: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser == OP_ERASE) |=>
		(m_axis_tvalid && m_axis_tuser == OP_HEADER))
		else $error("erase not followed by header");

	// erase and header never close a result set
	a_format_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == OP_ERASE || m_axis_tuser == OP_HEADER))
		|-> !m_axis_tlast)
		else $error("format beat marked last");

	// a beat without a flash operation is a whole result set
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == OP_NONE) |-> m_axis_tlast)
		else $error("plain result not last");

endmodule

`default_nettype wire
